@@ src/tked_pkg.sv @@
// Shared types and constants for the terminal key event decoder.
package tked_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_FUNC    = 3'd1,
    KIND_RIGHT   = 3'd2,
    KIND_LEFT    = 3'd3,
    KIND_ESC_ERR = 3'd4,
    KIND_DEC_ERR = 3'd5
  } key_kind_e;

  localparam int unsigned CpW   = 21;
  localparam int unsigned FnW   = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TdataW = ((CpW + FnW + 7) / 8) * 8;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [ByteW-1:0] ChEsc   = 8'h1B;
  localparam logic [ByteW-1:0] ChO     = 8'h4F;
  localparam logic [ByteW-1:0] ChBrk   = 8'h5B;
  localparam logic [ByteW-1:0] ChTilde = 8'h7E;
  localparam logic [ByteW-1:0] ChRight = 8'h43;
  localparam logic [ByteW-1:0] ChLeft  = 8'h44;
  localparam logic [ByteW-1:0] ChOne   = 8'h31;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] ChS     = 8'h53;

  localparam logic [CpW-1:0] Min2     = 21'h000080;
  localparam logic [CpW-1:0] Min3     = 21'h000800;
  localparam logic [CpW-1:0] Min4     = 21'h010000;
  localparam logic [CpW-1:0] SurLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurHi    = 21'h00E000;
  localparam logic [CpW-1:0] CpLimit  = 21'h110000;

  // One queued job: first event plus trailing decode errors
  typedef struct packed {
    key_kind_e        kind;
    logic [CpW-1:0]   code_point;
    logic [FnW-1:0]   function_number;
    logic [1:0]       extra_errs;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ src/tked_front.sv @@
// Byte parser: UTF-8 and escape sequence state machine, emits event jobs.
module tked_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [tked_pkg::ByteW-1:0]  byte_i,
  output logic                        job_push_o,
  output tked_pkg::job_t              job_o
);
  import tked_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_UTF8   = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_ESC_O  = 3'd3,
    MODE_CSI    = 3'd4,
    MODE_CSI_1  = 3'd5,
    MODE_CSI_1D = 3'd6
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [1:0]     pend_q, pend_d;
  logic [1:0]     held_q, held_d;
  logic [1:0]     lead_q, lead_d;
  logic [CpW-1:0] part_q, part_d;

  logic [CpW-1:0] shifted;
  logic           bad;

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    held_d = held_q;
    lead_d = lead_q;
    part_d = part_q;
    job_push_o = 1'b0;
    job_o = '0;
    shifted = {part_q[CpW-7:0], byte_i[5:0]};
    case (lead_q)
      2'd2:    bad = shifted < Min2;
      2'd3:    bad = (shifted < Min3) || ((shifted >= SurLo) && (shifted < SurHi));
      default: bad = (shifted < Min4) || (shifted >= CpLimit);
    endcase

    case (mode_q)
      MODE_UTF8: begin
        if (byte_i == ChEsc) begin
          job_push_o = 1'b1;
          job_o.kind = KIND_ESC_ERR;
          job_o.extra_errs = (held_q == 2'd0) ? 2'd0 : held_q - 2'd1;
          mode_d = MODE_IDLE;
        end else if (byte_i[7:6] != 2'b10) begin
          job_push_o = 1'b1;
          job_o.kind = KIND_DEC_ERR;
          mode_d = MODE_IDLE;
        end else begin
          part_d = shifted;
          held_d = held_q + 2'd1;
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            job_push_o = 1'b1;
            if (bad) begin
              job_o.kind = KIND_DEC_ERR;
            end else begin
              job_o.kind = KIND_CHAR;
              job_o.code_point = shifted;
            end
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_ESC: begin
        if (byte_i == ChO) begin
          mode_d = MODE_ESC_O;
        end else if (byte_i == ChBrk) begin
          mode_d = MODE_CSI;
        end else begin
          job_push_o = 1'b1;
          job_o.kind = KIND_ESC_ERR;
          mode_d = MODE_IDLE;
        end
      end
      MODE_ESC_O: begin
        job_push_o = 1'b1;
        if (byte_i >= ChP && byte_i <= ChS) begin
          job_o.kind = KIND_FUNC;
          job_o.function_number = {2'b00, byte_i[1:0]} + 4'd1;
        end else begin
          job_o.kind = KIND_ESC_ERR;
        end
        mode_d = MODE_IDLE;
      end
      MODE_CSI: begin
        if (byte_i == ChOne) begin
          mode_d = MODE_CSI_1;
        end else begin
          job_push_o = 1'b1;
          if (byte_i == ChRight) job_o.kind = KIND_RIGHT;
          else if (byte_i == ChLeft) job_o.kind = KIND_LEFT;
          else job_o.kind = KIND_ESC_ERR;
          mode_d = MODE_IDLE;
        end
      end
      MODE_CSI_1: begin
        if (byte_i >= ChOne && byte_i <= ChNine) begin
          part_d = {{(CpW-FnW){1'b0}}, byte_i[FnW-1:0]};
          mode_d = MODE_CSI_1D;
        end else begin
          job_push_o = 1'b1;
          job_o.kind = KIND_ESC_ERR;
          mode_d = MODE_IDLE;
        end
      end
      MODE_CSI_1D: begin
        job_push_o = 1'b1;
        if (byte_i == ChTilde) begin
          job_o.kind = KIND_FUNC;
          job_o.function_number = part_q[FnW-1:0];
        end else begin
          job_o.kind = KIND_ESC_ERR;
        end
        mode_d = MODE_IDLE;
      end
      default: begin
        mode_d = MODE_IDLE;
        pend_d = 2'd0;
        held_d = 2'd0;
        lead_d = 2'd0;
        part_d = '0;
        if (byte_i == ChEsc) begin
          mode_d = MODE_ESC;
        end else if (!byte_i[7]) begin
          job_push_o = 1'b1;
          job_o.kind = KIND_CHAR;
          job_o.code_point = {{(CpW-ByteW){1'b0}}, byte_i};
        end else if (byte_i >= 8'hC2 && byte_i <= 8'hF7) begin
          held_d = 2'd1;
          mode_d = MODE_UTF8;
          if (byte_i <= 8'hDF) begin
            lead_d = 2'd2;
            pend_d = 2'd1;
            part_d = {{(CpW-5){1'b0}}, byte_i[4:0]};
          end else if (byte_i <= 8'hEF) begin
            lead_d = 2'd3;
            pend_d = 2'd2;
            part_d = {{(CpW-4){1'b0}}, byte_i[3:0]};
          end else begin
            lead_d = 2'd0;  // four-byte form
            pend_d = 2'd3;
            part_d = {{(CpW-3){1'b0}}, byte_i[2:0]};
          end
        end else begin
          job_push_o = 1'b1;
          job_o.kind = KIND_DEC_ERR;
        end
      end
    endcase

    if (!byte_valid_i) begin
      mode_d = mode_q;
      pend_d = pend_q;
      held_d = held_q;
      lead_d = lead_q;
      part_d = part_q;
      job_push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= 2'd0;
      held_q <= 2'd0;
      lead_q <= 2'd0;
      part_q <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      held_q <= held_d;
      lead_q <= lead_d;
      part_q <= part_d;
    end
  end

endmodule

@@ src/tked_fifo.sv @@
// Short job queue between the parser and the event emitter.
module tked_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tked_pkg::job_t      push_job_i,
  input  logic                pop_i,
  output tked_pkg::job_t      head_o,
  output tked_pkg::q_stat_t   stat_o
);
  import tked_pkg::*;

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q, cnt_d;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QAw'(0) + (QAw+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_job_i;
  end

endmodule

@@ src/tked_back.sv @@
// Event emitter: expands queued jobs into result transactions.
module tked_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tked_pkg::job_t             head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [tked_pkg::TdataW-1:0] m_axis_tdata,
  output logic [2:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);
  import tked_pkg::*;

  logic [1:0]     idx_q;
  logic           vld_q;
  key_kind_e      kind_q;
  logic [CpW-1:0] cp_q;
  logic [FnW-1:0] fn_q;
  logic           last_q;
  logic           load, last;

  assign load  = !empty_i && (!vld_q || m_axis_tready);
  assign last  = (idx_q == head_i.extra_errs);
  assign pop_o = load && last;

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {{(TdataW-CpW-FnW){1'b0}}, fn_q, cp_q};
  assign m_axis_tlast  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (load) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
      if (load) idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= last;
      if (idx_q == 2'd0) begin
        kind_q <= head_i.kind;
        cp_q   <= head_i.code_point;
        fn_q   <= head_i.function_number;
      end else begin
        kind_q <= KIND_DEC_ERR;
        cp_q   <= '0;
        fn_q   <= '0;
      end
    end
  end

endmodule

@@ src/terminal_key_event_decoder.sv @@
// Top level of the terminal key event decoder.
// Usage:
//   Slave stream takes one raw terminal byte per transaction (tdata[7:0]).
//   Master stream gives key events: tuser = key kind, tdata = code point
//   and function key number, tlast marks the final event caused by a byte.
//   A byte is parsed in the cycle it is taken and its job is queued at that
//   edge; the output register then loads the job from the queue once that
//   register is free. Prefix bytes of escape sequences and inner UTF-8 bytes
//   produce no event.
//   Throughput is one byte per cycle while the queue has room; an ESC inside
//   a partial UTF-8 sequence yields up to three events, one per cycle while
//   the receiver is ready, from the single output register, which sets the rate.
//   A four-entry job queue decouples the parser from the output; when the
//   receiver stalls, events hold in the output register, the queue fills
//   and s_axis_tready drops once it is full.
//   Reset returns the parser to idle and empties the queue and output.
module terminal_key_event_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] input_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [tked_pkg::TdataW-1:0]  m_axis_tdata,   // [20:0] code_point, [24:21] function_number
  output logic [2:0]                   m_axis_tuser,   // [2:0] key_kind
  output logic                         m_axis_tlast    // last_of_run
);
  import tked_pkg::*;

  logic    acc;
  logic    push, pop;
  job_t    push_job, head;
  q_stat_t q_stat;

  assign s_axis_tready = !q_stat.full;
  assign acc = s_axis_tvalid && s_axis_tready;

  tked_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (acc),
    .byte_i       (s_axis_tdata),
    .job_push_o   (push),
    .job_o        (push_job)
  );

  tked_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  tked_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_stat.empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_cp_only_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_CHAR) |-> (m_axis_tdata[CpW-1:0] == '0))
    else $error("code point set on a non-character event");

  a_fn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FUNC) |->
      (m_axis_tdata[CpW+FnW-1:CpW] != '0) && (m_axis_tdata[CpW+FnW-1:CpW] <= 4'd9))
    else $error("function key number out of range");

  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("job queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("job queue popped while empty");
`endif

endmodule

@@ tb/tb_terminal_key_event_decoder.sv @@
// Self-checking testbench for the terminal key event decoder: byte stream in, key events out.
`timescale 1ns / 1ps

module tb_terminal_key_event_decoder;
  import tked_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned RandBytes  = 360;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailCycles = 20;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UTF8, ST_ESC, ST_ESC_O, ST_CSI, ST_CSI_1, ST_CSI_1D
  } dec_mode_e;

  typedef struct {
    key_kind_e         kind;
    logic [CpW-1:0]    cp;
    logic [FnW-1:0]    fn;
    logic              last;
  } key_event_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TdataW-1:0]   m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tlast;

  logic [7:0]          stim_bytes[$];
  key_event_t          pending_events[$];
  int unsigned         total_bytes  = 0;
  int unsigned         bytes_taken  = 0;
  int unsigned         fail_count   = 0;
  int unsigned         idle_cycles  = 0;
  int unsigned         send_gap     = 0;
  int unsigned         recv_stall   = 0;
  logic                send_calm    = 1'b0;
  logic                recv_calm    = 1'b0;

  // decoder state as seen by the predictor
  dec_mode_e           dec_mode     = ST_IDLE;
  int unsigned         cont_left    = 0;
  int unsigned         bytes_held   = 0;
  int unsigned         seq_len      = 0;
  logic [CpW-1:0]      acc          = '0;

  terminal_key_event_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic key_event_t key_event(input key_kind_e k, input logic [CpW-1:0] cp,
                                           input logic [FnW-1:0] fn);
    key_event_t e;
    e.kind = k;
    e.cp   = cp;
    e.fn   = fn;
    e.last = 1'b0;
    return e;
  endfunction

  task automatic return_to_idle();
    dec_mode   = ST_IDLE;
    cont_left  = 0;
    bytes_held = 0;
    seq_len    = 0;
    acc        = '0;
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Works out the key events one byte gives and queues them
  task automatic decode_byte(input logic [7:0] b);
    key_event_t  evs[$];
    logic        bad;
    logic [7:0]  digit;
    int unsigned i;
    case (dec_mode)
      ST_UTF8: begin
        if (b == ChEsc) begin
          evs.push_back(key_event(KIND_ESC_ERR, '0, '0));
          for (i = 1; i < bytes_held && evs.size() < 3; i++)
            evs.push_back(key_event(KIND_DEC_ERR, '0, '0));
          return_to_idle();
        end else if (b < 8'h80 || b > 8'hBF) begin
          evs.push_back(key_event(KIND_DEC_ERR, '0, '0));
          return_to_idle();
        end else begin
          acc = {acc[CpW-7:0], b[5:0]};
          bytes_held++;
          cont_left--;
          if (cont_left == 0) begin
            if (seq_len == 2) bad = acc < Min2;
            else if (seq_len == 3) bad = acc < Min3 || (acc >= SurLo && acc < SurHi);
            else bad = acc < Min4 || acc >= CpLimit;
            evs.push_back(bad ? key_event(KIND_DEC_ERR, '0, '0) : key_event(KIND_CHAR, acc, '0));
            return_to_idle();
          end
        end
      end
      ST_ESC: begin
        if (b == ChO) dec_mode = ST_ESC_O;
        else if (b == ChBrk) dec_mode = ST_CSI;
        else begin
          evs.push_back(key_event(KIND_ESC_ERR, '0, '0));
          return_to_idle();
        end
      end
      ST_ESC_O: begin
        digit = b - ChP + 8'd1;
        if (b >= ChP && b <= ChS) evs.push_back(key_event(KIND_FUNC, '0, digit[FnW-1:0]));
        else evs.push_back(key_event(KIND_ESC_ERR, '0, '0));
        return_to_idle();
      end
      ST_CSI: begin
        if (b == ChOne) dec_mode = ST_CSI_1;
        else begin
          if (b == ChRight) evs.push_back(key_event(KIND_RIGHT, '0, '0));
          else if (b == ChLeft) evs.push_back(key_event(KIND_LEFT, '0, '0));
          else evs.push_back(key_event(KIND_ESC_ERR, '0, '0));
          return_to_idle();
        end
      end
      ST_CSI_1: begin
        if (b >= ChOne && b <= ChNine) begin
          digit    = b - ChOne + 8'd1;
          acc      = {{(CpW-8){1'b0}}, digit};
          dec_mode = ST_CSI_1D;
        end else begin
          evs.push_back(key_event(KIND_ESC_ERR, '0, '0));
          return_to_idle();
        end
      end
      ST_CSI_1D: begin
        if (b == ChTilde) evs.push_back(key_event(KIND_FUNC, '0, acc[FnW-1:0]));
        else evs.push_back(key_event(KIND_ESC_ERR, '0, '0));
        return_to_idle();
      end
      default: begin
        return_to_idle();
        if (b == ChEsc) begin
          dec_mode = ST_ESC;
        end else if (b <= 8'h7F) begin
          evs.push_back(key_event(KIND_CHAR, {{(CpW-8){1'b0}}, b}, '0));
        end else if (b >= 8'hC2 && b <= 8'hF7) begin
          if (b <= 8'hDF) begin
            seq_len = 2;
            acc     = {{(CpW-5){1'b0}}, b[4:0]};
          end else if (b <= 8'hEF) begin
            seq_len = 3;
            acc     = {{(CpW-4){1'b0}}, b[3:0]};
          end else begin
            seq_len = 4;
            acc     = {{(CpW-3){1'b0}}, b[2:0]};
          end
          cont_left  = seq_len - 1;
          bytes_held = 1;
          dec_mode   = ST_UTF8;
        end else begin
          evs.push_back(key_event(KIND_DEC_ERR, '0, '0));
        end
      end
    endcase
    if (evs.size() != 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endtask

  // Mostly well-formed UTF-8 and key sequences with random content, plus noise
  task automatic add_random_sequence();
    int unsigned    sel, len, pos, roll, i;
    logic [CpW-1:0] v;
    logic [7:0]     lead;
    logic [7:0]     seq[$];
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      seq.push_back(8'($urandom_range(0, 127)));
    end else if (sel < 40) begin
      len = $urandom_range(2, 4);
      if (len == 2) v = 21'($urandom_range(32'h80, 32'h7FF));
      else if (len == 3) begin
        v = 21'($urandom_range(32'h800, 32'hFFFF));
        if (v >= SurLo && v < SurHi) v = v + 21'h800;
      end else v = 21'($urandom_range(32'h10000, 32'h10FFFF));
      case (len)
        2: seq.push_back({3'b110, v[10:6]});
        3: begin
          seq.push_back({4'b1110, v[15:12]});
          seq.push_back({2'b10, v[11:6]});
        end
        default: begin
          seq.push_back({5'b11110, v[20:18]});
          seq.push_back({2'b10, v[17:12]});
          seq.push_back({2'b10, v[11:6]});
        end
      endcase
      seq.push_back({2'b10, v[5:0]});
    end else if (sel < 55) begin
      // random continuations hit overlong, surrogate and out-of-range forms
      lead = 8'($urandom_range(8'hC2, 8'hF7));
      seq.push_back(lead);
      len = (lead <= 8'hDF) ? 2 : (lead <= 8'hEF) ? 3 : 4;
      for (i = 1; i < len; i++) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else begin
          seq.push_back((roll == 7) ? ChEsc : 8'($urandom_range(0, 255)));
          break;
        end
      end
    end else if (sel < 90) begin
      seq.push_back(ChEsc);
      case ($urandom_range(0, 2))
        0: begin
          seq.push_back(ChO);
          seq.push_back(ChP + 8'($urandom_range(0, 3)));
        end
        1: begin
          seq.push_back(ChBrk);
          seq.push_back(($urandom_range(0, 1) != 0) ? ChRight : ChLeft);
        end
        default: begin
          seq.push_back(ChBrk);
          seq.push_back(ChOne);
          seq.push_back(ChOne + 8'($urandom_range(0, 8)));
          seq.push_back(ChTilde);
        end
      endcase
      if (sel >= 80) begin
        // cut the sequence short and finish with a random byte
        pos = $urandom_range(1, seq.size() - 1);
        while (seq.size() > pos) void'(seq.pop_back());
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[k]) stim_bytes.push_back(seq[k]);
  endtask

  // Byte sender
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) send_calm <= ~send_calm;
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (stim_bytes.size() != 0) begin
        s_axis_tdata  <= stim_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap      <= pick_gap(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Event receiver with random back-pressure
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) recv_calm <= ~recv_calm;
    if (rst_ni) begin
      if (recv_stall != 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    <= pick_gap(recv_calm);
      end
    end
  end

  // Monitor: predict on each byte transaction, check each event transaction
  always @(posedge clk_i) begin : mon
    key_event_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d tdata %h last %b",
                                    m_axis_tuser, m_axis_tdata, m_axis_tlast));
        end else begin
          want = pending_events.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[CpW-1:0] !== want.cp ||
              m_axis_tdata[CpW+FnW-1:CpW] !== want.fn ||
              m_axis_tdata[TdataW-1:CpW+FnW] !== '0 || m_axis_tlast !== want.last)
            report_mismatch($sformatf(
              "got kind %0d cp %h fn %0d last %b tdata %h, want kind %0d cp %h fn %0d last %b",
              m_axis_tuser, m_axis_tdata[CpW-1:0], m_axis_tdata[CpW+FnW-1:CpW], m_axis_tlast,
              m_axis_tdata, want.kind, want.cp, want.fn, want.last));
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("[%0t] watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] directed[] = '{
      8'h00, 8'hFF,                            // field extremes, invalid lead
      8'hC2, 8'h80,                            // smallest two-byte scalar
      8'hF4, 8'h8F, 8'hBF, 8'hBF,              // largest scalar
      8'hED, 8'hA0, 8'h80,                     // surrogate
      8'hC3, 8'h41,                            // bad continuation, byte consumed
      8'hF0, 8'h90, 8'h80, ChEsc,              // ESC inside partial sequence
      ChEsc, ChO, ChS,
      ChEsc, ChBrk, ChLeft,
      ChEsc, ChBrk, ChOne, ChNine, ChTilde,
      ChEsc, ChEsc                             // ESC after ESC
    };
    foreach (directed[k]) stim_bytes.push_back(directed[k]);
    while (stim_bytes.size() < directed.size() + RandBytes) add_random_sequence();
    total_bytes = stim_bytes.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (bytes_taken != total_bytes || pending_events.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tked_pkg.sv
src/tked_front.sv
src/tked_fifo.sv
src/tked_back.sv
src/terminal_key_event_decoder.sv
tb/tb_terminal_key_event_decoder.sv
